// ===== design/pla_pkg.sv =====
package pla_pkg;

	localparam int COORD_BITS_DEF = 24;
	localparam int SUM_BITS_DEF   = 40;

	typedef struct packed {
		logic valid;
		logic last;
	} pla_tag_t;

endpackage

// ===== design/polyline_length_accumulator.sv =====
// polyline length accumulator
// input channel s_*: one point per item, x and y in tdata, tlast marks the
// final point of a polyline. output channel m_*: one result per point, the
// running length in tdata, tlast set on the full length of a line, tuser set
// when the sum sits at its maximum value.
// the first point of a line adds nothing; each later point adds the floored
// euclidean distance to the point before it. after a point marked last the
// sum and the stored point start afresh.
// the pipeline registers, in order, are the difference, the square and the
// sum of squares, then the square root cell chain with a cell for each root
// bit, then the accumulator.
// throughput is one point per cycle unless the receiver stalls; the whole pipeline moves together.
// when the receiver stalls with a result pending, every stage holds and
// s_tready drops until the result is taken.
// reset clears the stored point, the sum and all stage valid flags.
module polyline_length_accumulator #(
	parameter int COORD_BITS = pla_pkg::COORD_BITS_DEF,
	parameter int SUM_BITS   = pla_pkg::SUM_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// x_coord, y_coord
	input  logic [((2*COORD_BITS+7)/8)*8-1:0]   s_tdata,
	input  logic                                s_tlast,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// running_length
	output logic [((SUM_BITS+7)/8)*8-1:0]       m_tdata,
	output logic                                m_tlast,
	// length_saturated
	output logic                                m_tuser
);
	import pla_pkg::*;

	localparam int R  = COORD_BITS + 1;
	localparam int AW = ((SUM_BITS > R) ? SUM_BITS : R) + 1;
	localparam int OW = ((SUM_BITS + 7) / 8) * 8;

	logic     en;
	pla_tag_t in_tag;

	pla_tag_t       tag_c  [0:R];
	logic [2*R-1:0] rad_c  [0:R];
	logic [R+1:0]   rem_c  [0:R];
	logic [R-1:0]   root_c [0:R];

	logic [SUM_BITS-1:0] sum_q;
	logic [AW-1:0]       sum_ext;
	logic                over;
	logic [SUM_BITS-1:0] sum_new;

	logic                m_valid_q;
	logic [SUM_BITS-1:0] out_len_q;
	logic                out_last_q;
	logic                out_sat_q;

	assign en           = !m_valid_q || m_tready;
	assign s_tready     = en;
	assign in_tag.valid = s_tvalid;
	assign in_tag.last  = s_tlast;

	pla_diff_sq #(
		.COORD_BITS(COORD_BITS)
	) u_diff_sq (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_tag  (in_tag),
		.x_coord (s_tdata[COORD_BITS-1:0]),
		.y_coord (s_tdata[2*COORD_BITS-1:COORD_BITS]),
		.out_tag (tag_c[0]),
		.radicand(rad_c[0])
	);

	assign rem_c[0]  = '0;
	assign root_c[0] = '0;

	for (genvar i = 0; i < R; i++) begin : g_cell
		pla_sqrt_cell #(
			.ROOT_BITS(R)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.in_tag  (tag_c[i]),
			.in_rad  (rad_c[i]),
			.in_rem  (rem_c[i]),
			.in_root (root_c[i]),
			.out_tag (tag_c[i+1]),
			.out_rad (rad_c[i+1]),
			.out_rem (rem_c[i+1]),
			.out_root(root_c[i+1])
		);
	end

	assign sum_ext = AW'(sum_q) + AW'(root_c[R]);
	assign over    = sum_ext > AW'({SUM_BITS{1'b1}});
	assign sum_new = over ? {SUM_BITS{1'b1}} : sum_ext[SUM_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q     <= '0;
			m_valid_q <= 1'b0;
		end else if (en) begin
			m_valid_q <= tag_c[R].valid;
			if (tag_c[R].valid) begin
				sum_q <= tag_c[R].last ? '0 : sum_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && tag_c[R].valid) begin
			out_len_q  <= sum_new;
			out_last_q <= tag_c[R].last;
			out_sat_q  <= &sum_new;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OW'(out_len_q);
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_sat_q;

endmodule

// ===== design/pla_diff_sq.sv =====
module pla_diff_sq #(
	parameter int COORD_BITS = pla_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  pla_pkg::pla_tag_t             in_tag,
	input  logic [COORD_BITS-1:0]         x_coord,
	input  logic [COORD_BITS-1:0]         y_coord,
	output pla_pkg::pla_tag_t             out_tag,
	output logic [2*(COORD_BITS+1)-1:0]   radicand
);
	import pla_pkg::*;

	localparam int R = COORD_BITS + 1;

	logic [COORD_BITS-1:0] prev_x_q;
	logic [COORD_BITS-1:0] prev_y_q;
	logic                  have_prev_q;

	logic signed [R-1:0] dx;
	logic signed [R-1:0] dy;
	logic [R-1:0]        mag_x;
	logic [R-1:0]        mag_y;

	logic [R-1:0]   mag_x_s1;
	logic [R-1:0]   mag_y_s1;
	pla_tag_t       tag_s1;
	logic [2*R-1:0] sq_x;
	logic [2*R-1:0] sq_y;
	logic [2*R-1:0] sq_x_s2;
	logic [2*R-1:0] sq_y_s2;
	pla_tag_t       tag_s2;
	logic [2*R-1:0] rad_s3;
	pla_tag_t       tag_s3;

	// first point of a line gives a zero distance
	always_comb begin
		if (have_prev_q) begin
			dx = $signed({x_coord[COORD_BITS-1], x_coord}) - $signed({prev_x_q[COORD_BITS-1], prev_x_q});
			dy = $signed({y_coord[COORD_BITS-1], y_coord}) - $signed({prev_y_q[COORD_BITS-1], prev_y_q});
		end else begin
			dx = '0;
			dy = '0;
		end
		mag_x = dx[R-1] ? R'(-dx) : R'(dx);
		mag_y = dy[R-1] ? R'(-dy) : R'(dy);
	end

	assign sq_x = mag_x_s1 * mag_x_s1;
	assign sq_y = mag_y_s1 * mag_y_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			tag_s1      <= '0;
			tag_s2      <= '0;
			tag_s3      <= '0;
		end else if (en) begin
			if (in_tag.valid) begin
				prev_x_q    <= x_coord;
				prev_y_q    <= y_coord;
				have_prev_q <= !in_tag.last;
			end
			tag_s1 <= in_tag;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_x_s1 <= mag_x;
			mag_y_s1 <= mag_y;
			sq_x_s2  <= sq_x;
			sq_y_s2  <= sq_y;
			rad_s3   <= sq_x_s2 + sq_y_s2;
		end
	end

	assign out_tag  = tag_s3;
	assign radicand = rad_s3;

endmodule

// ===== design/pla_sqrt_cell.sv =====
module pla_sqrt_cell #(
	parameter int ROOT_BITS = pla_pkg::COORD_BITS_DEF + 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  pla_pkg::pla_tag_t       in_tag,
	input  logic [2*ROOT_BITS-1:0]  in_rad,
	input  logic [ROOT_BITS+1:0]    in_rem,
	input  logic [ROOT_BITS-1:0]    in_root,
	output pla_pkg::pla_tag_t       out_tag,
	output logic [2*ROOT_BITS-1:0]  out_rad,
	output logic [ROOT_BITS+1:0]    out_rem,
	output logic [ROOT_BITS-1:0]    out_root
);
	import pla_pkg::*;

	localparam int RW = ROOT_BITS + 2;

	logic [RW+1:0] rem_sh;
	logic [RW+1:0] trial;
	logic          fits;

	pla_tag_t               tag_q;
	logic [2*ROOT_BITS-1:0] rad_q;
	logic [RW-1:0]          rem_q;
	logic [ROOT_BITS-1:0]   root_q;

	// one restoring step on the next bit pair
	assign rem_sh = {in_rem, in_rad[2*ROOT_BITS-1 -: 2]};
	assign trial  = (RW+2)'({in_root, 2'b01});
	assign fits   = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
		end else if (en) begin
			tag_q <= in_tag;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_q  <= {in_rad[2*ROOT_BITS-3:0], 2'b00};
			rem_q  <= fits ? RW'(rem_sh - trial) : RW'(rem_sh);
			root_q <= {in_root[ROOT_BITS-2:0], fits};
		end
	end

	assign out_tag  = tag_q;
	assign out_rad  = rad_q;
	assign out_rem  = rem_q;
	assign out_root = root_q;

endmodule
